// ===== rtl/core/bss_pkg.sv =====
`timescale 1ns / 1ps

package bss_pkg;

    // Program addresses of the control store
    typedef logic [2:0] t_step;

    localparam t_step S_LOAD  = 3'd0;
    localparam t_step S_START = 3'd1;
    localparam t_step S_PASS  = 3'd2;
    localparam t_step S_SCAN  = 3'd3;
    localparam t_step S_STEP  = 3'd4;
    localparam t_step S_WAIT  = 3'd5;
    localparam t_step S_EMIT  = 3'd6;
    localparam t_step S_RET   = 3'd7;

    // Jump conditions: jump to target when true, else fall through
    typedef enum logic [2:0] {
        C_NONE      = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_LAST   = 3'd2,
        C_SCAN_MORE = 3'd3,
        C_BIT_MORE  = 3'd4,
        C_DIV_BUSY  = 3'd5,
        C_OUT_BUSY  = 3'd6
    } t_cond;

    // One control word
    typedef struct packed {
        logic  load;       // take samples from the input channel
        logic  start;      // launch divider, reset median search
        logic  pass_init;  // rewind memory scan and counters
        logic  scan;       // stream the memory through the comparators
        logic  pass_end;   // settle one bit of both order statistics
        logic  emit;       // load the output register, clear the set
        t_cond cond;
        t_step target;
    } t_ctrl;

    // Control store
    function automatic t_ctrl ctrl_rom(input t_step addr);
        t_ctrl w;
        w = '{load: 1'b0, start: 1'b0, pass_init: 1'b0, scan: 1'b0,
              pass_end: 1'b0, emit: 1'b0, cond: C_NONE, target: S_LOAD};
        case (addr)
            S_LOAD: begin
                w.load   = 1'b1;
                w.cond   = C_NO_LAST;
                w.target = S_LOAD;
            end
            S_START: begin
                w.start = 1'b1;
            end
            S_PASS: begin
                w.pass_init = 1'b1;
            end
            S_SCAN: begin
                w.scan   = 1'b1;
                w.cond   = C_SCAN_MORE;
                w.target = S_SCAN;
            end
            S_STEP: begin
                w.pass_end = 1'b1;
                w.cond     = C_BIT_MORE;
                w.target   = S_PASS;
            end
            S_WAIT: begin
                w.cond   = C_DIV_BUSY;
                w.target = S_WAIT;
            end
            S_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.target = S_EMIT;
            end
            S_RET: begin
                w.cond   = C_ALWAYS;
                w.target = S_LOAD;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/byte_set_statistics_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Bus fields (low bit up)
// s_axis    in   tdata[7:0] sample, tlast = final sample of the set
// m_axis    out  tdata[7:0] minimum, [15:8] maximum, [23:16] mean,
//                [31:24] median, [38:32] count, [39] overflow
//
// Samples load at one per cycle. After the final sample, a short control
// program runs: eight bit-wise selection passes over the single-read-port
// sample memory find both middle order statistics, while a restoring
// divider forms the mean in parallel. No input is taken while the program
// runs; the result waits in an output register and a stalled consumer only
// holds the program at its emit step.
// Reset is synchronous, active low, and clears the set; no memory sweep.
module byte_set_statistics_top #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // sample
    input  logic        i_s_axis_tlast,   // last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // minimum, maximum, mean, median,
                                          // count, overflow
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(CAPACITY * 255 + 1);

    // Program sequencer
    bss_pkg::t_step r_step, n_step;
    bss_pkg::t_ctrl ctrl;
    logic           take;

    // Set statistics
    logic [NW-1:0] r_kept;
    logic [7:0]    r_min, r_max;
    logic [SW-1:0] r_sum;
    logic          r_drop;
    logic [7:0]    r_mem [CAPACITY];

    // Median search
    logic [NW-1:0] r_addr;
    logic          r_dv;
    logic [7:0]    r_rd;
    logic [NW-1:0] r_cnt_a, r_cnt_b;
    logic [7:0]    r_pref_a, r_pref_b;
    logic [2:0]    r_bit;
    logic [7:0]    bit_mask, trial_a, trial_b;
    logic [31:0]   n32;
    logic [NW-1:0] k_a, k_b;
    logic          issue;

    // Output
    logic          r_out_valid;
    logic [39:0]   r_out;
    logic          out_busy, emit_go;
    logic          in_fire, not_full;
    logic          div_busy;
    logic [7:0]    mean_q;
    logic [8:0]    mid_sum;

    assign ctrl     = bss_pkg::ctrl_rom(r_step);
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign not_full = r_kept < NW'(CAPACITY);
    assign out_busy = r_out_valid && !i_m_axis_tready;
    assign emit_go  = ctrl.emit && !out_busy;
    assign issue    = r_addr < r_kept;

    // Ranks of the two middle elements in descending order (1-based)
    assign n32      = 32'(r_kept);
    assign k_b      = NW'((n32 >> 1) + 32'd1);
    assign k_a      = n32[0] ? k_b : NW'(n32 >> 1);
    assign bit_mask = 8'd1 << r_bit;
    assign trial_a  = r_pref_a | bit_mask;
    assign trial_b  = r_pref_b | bit_mask;
    assign mid_sum  = 9'(r_pref_a) + 9'(r_pref_b);

    // Evaluate jump condition
    always_comb begin
        case (ctrl.cond)
            bss_pkg::C_ALWAYS:    take = 1'b1;
            bss_pkg::C_NO_LAST:   take = !(in_fire && i_s_axis_tlast);
            bss_pkg::C_SCAN_MORE: take = issue || r_dv;
            bss_pkg::C_BIT_MORE:  take = r_bit != 3'd0;
            bss_pkg::C_DIV_BUSY:  take = div_busy;
            bss_pkg::C_OUT_BUSY:  take = out_busy;
            default:              take = 1'b0;
        endcase
        n_step = take ? ctrl.target : r_step + 3'd1;
    end

    assign o_s_axis_tready = ctrl.load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= bss_pkg::S_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

    // Accumulate the set; clear it once the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept <= '0;
            r_min  <= 8'hFF;
            r_max  <= 8'h00;
            r_sum  <= '0;
            r_drop <= 1'b0;
        end else if (emit_go) begin
            r_kept <= '0;
            r_min  <= 8'hFF;
            r_max  <= 8'h00;
            r_sum  <= '0;
            r_drop <= 1'b0;
        end else if (in_fire) begin
            if (not_full) begin
                r_kept <= r_kept + NW'(1);
                if (i_s_axis_tdata < r_min) r_min <= i_s_axis_tdata;
                if (i_s_axis_tdata > r_max) r_max <= i_s_axis_tdata;
                r_sum <= r_sum + SW'(i_s_axis_tdata);
            end else begin
                r_drop <= 1'b1;
            end
        end
    end

    // Sample memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_fire && not_full) begin
            r_mem[r_kept[AW-1:0]] <= i_s_axis_tdata;
        end
        r_rd <= r_mem[r_addr[AW-1:0]];
    end

    // Bit-wise selection of both middle order statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (ctrl.pass_init) begin
            r_dv <= 1'b0;
        end else if (ctrl.scan) begin
            r_dv <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.start) begin
            r_bit    <= 3'd7;
            r_pref_a <= 8'h00;
            r_pref_b <= 8'h00;
        end else if (ctrl.pass_end) begin
            r_bit <= r_bit - 3'd1;
            if (r_cnt_a >= k_a) r_pref_a <= trial_a;
            if (r_cnt_b >= k_b) r_pref_b <= trial_b;
        end
        if (ctrl.pass_init) begin
            r_addr  <= '0;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else if (ctrl.scan) begin
            if (issue) r_addr <= r_addr + NW'(1);
            if (r_dv && (r_rd >= trial_a)) r_cnt_a <= r_cnt_a + NW'(1);
            if (r_dv && (r_rd >= trial_b)) r_cnt_b <= r_cnt_b + NW'(1);
        end
    end

    bss_div #(
        .DW(SW),
        .VW(NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctrl.start),
        .i_dividend (r_sum),
        .i_divisor  (r_kept),
        .o_busy     (div_busy),
        .o_quot     (mean_q)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out <= {r_drop, n32[6:0], mid_sum[8:1], mean_q, r_max, r_min};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= NW'(CAPACITY))
        else $error("kept count above capacity");
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go |=> (r_kept == '0) && !r_drop && o_m_axis_tvalid)
        else $error("set not cleared after result");
    a_emit_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.emit |-> !div_busy)
        else $error("result taken before mean settled");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.scan |-> r_addr <= r_kept)
        else $error("scan ran past kept samples");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.start |-> r_kept != '0)
        else $error("statistics started on empty set");
`endif

endmodule

// ===== rtl/core/bss_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module bss_div #(
    parameter int DW = 14,
    parameter int VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [7:0]    o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic [VW:0]   r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW-1:0] r_dvs, n_dvs;
    logic [VW:0]   rem_sh;
    logic          ge;

    // Shift in the next dividend bit and try to subtract
    always_comb begin
        rem_sh = {r_rem[VW-1:0], r_quo[DW-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_cnt = CW'(DW);
            n_rem = '0;
            n_quo = i_dividend;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CW'(1);
            n_rem = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            n_quo = {r_quo[DW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quo[7:0];

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_cnt == '0)
        else $error("divider restarted while busy");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> r_rem < {1'b0, r_dvs})
        else $error("partial remainder not below divisor");
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_cnt == CW'(DW))
        else $error("divider run length wrong");
`endif

endmodule

// ===== sim/byte_set_statistics_checker.sv =====
`timescale 1ns / 1ps

module byte_set_statistics_checker #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // sample
    input  logic        i_s_tlast,    // last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,    // minimum, maximum, mean, median,
                                      // count, overflow
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // One result item, minimum in the low byte as on the bus
    typedef struct packed {
        logic       overflow;
        logic [6:0] count;
        logic [7:0] median;
        logic [7:0] mean;
        logic [7:0] maximum;
        logic [7:0] minimum;
    } set_stats_t;

    logic [7:0]  kept [CAPACITY];
    int unsigned kept_n;
    logic [7:0]  low_mark;
    logic [7:0]  high_mark;
    logic [13:0] byte_total;
    logic        lost_any;
    set_stats_t  stats_due [$];
    int          fails;
    int          checked;

    assign o_fail_count = fails;
    assign o_pending    = stats_due.size();
    assign o_checked    = checked;

    // Sort the kept samples high to low and pick the middle one or two
    function automatic logic [7:0] median_of_kept(input int unsigned n);
        logic [7:0] order [CAPACITY];
        logic [7:0] v;
        logic [8:0] pair;
        int         j;
        for (int i = 0; i < n; i++) begin
            v = kept[i];
            j = i;
            while (j > 0 && order[j-1] < v) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
        end
        if ((n % 2) == 1)
            return order[n/2];
        pair = {1'b0, order[n/2-1]} + {1'b0, order[n/2]};
        return pair[8:1];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fails++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic clear_set();
        kept_n     = 0;
        low_mark   = 8'd255;
        high_mark  = 8'd0;
        byte_total = '0;
        lost_any   = 1'b0;
    endtask

    initial begin
        fails   = 0;
        checked = 0;
        clear_set();
    end

    // Compare each result item first, then fold in the accepted sample
    always @(posedge i_clk) begin
        set_stats_t got;
        set_stats_t want;
        if (!i_rst_n) begin
            clear_set();
            stats_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = set_stats_t'(i_m_tdata);
                checked++;
                if (stats_due.size() == 0) begin
                    report_mismatch($sformatf("result 0x%010h with no set closed", i_m_tdata));
                end else begin
                    want = stats_due.pop_front();
                    check_field("minimum", got.minimum, want.minimum);
                    check_field("maximum", got.maximum, want.maximum);
                    check_field("mean", got.mean, want.mean);
                    check_field("median", got.median, want.median);
                    check_field("count", {1'b0, got.count}, {1'b0, want.count});
                    check_field("overflow", {7'd0, got.overflow}, {7'd0, want.overflow});
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (kept_n < CAPACITY) begin
                    kept[kept_n] = i_s_tdata;
                    kept_n++;
                    if (i_s_tdata < low_mark)
                        low_mark = i_s_tdata;
                    if (i_s_tdata > high_mark)
                        high_mark = i_s_tdata;
                    byte_total = byte_total + i_s_tdata;
                end else begin
                    lost_any = 1'b1;
                end
                if (i_s_tlast) begin
                    want.minimum  = low_mark;
                    want.maximum  = high_mark;
                    want.mean     = 8'(byte_total / kept_n);
                    want.median   = median_of_kept(kept_n);
                    want.count    = 7'(kept_n);
                    want.overflow = lost_any;
                    stats_due.push_back(want);
                    clear_set();
                end
            end
        end
    end

endmodule

// ===== sim/byte_set_statistics_top_test.sv =====
`timescale 1ns / 1ps

module byte_set_statistics_top_test;

    localparam int CAPACITY     = 64;
    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 9;
    localparam int SAMPLE_GOAL  = 1350;
    localparam int HOLD_CYCLES  = 900;
    localparam int DRAIN_CYCLES = 600;
    localparam int IDLE_LIMIT   = 5000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata    = 8'd0;   // sample
    logic        s_tlast    = 1'b0;   // last
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [39:0] m_tdata;             // minimum, maximum, mean, median, count, overflow

    int          fail_count;
    int          pending;
    int          checked;

    logic [7:0]  set_bytes [$];
    int          burst_left = 4;
    bit          steady     = 1'b0;
    bit          hold_off   = 1'b0;
    logic [9:0]  rx_tick    = '0;
    int          idle_cycles = 0;
    int          samples_sent = 0;
    int          sets_sent = 0;
    int          full_sets = 0;
    int          dropping_sets = 0;

    always #HALF_PERIOD clk = ~clk;

    byte_set_statistics_top #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    byte_set_statistics_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Offer each item of the set, tlast on the final one; gaps fall between bursts
    task automatic send_set();
        int gap;
        for (int k = 0; k < set_bytes.size(); k++) begin
            s_tvalid <= 1'b1;
            s_tdata  <= set_bytes[k];
            s_tlast  <= (k == set_bytes.size() - 1);
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            @(negedge clk);
            samples_sent++;
            if (!steady) begin
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap = $urandom_range(1, 8);
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
        sets_sent++;
        if (set_bytes.size() >= CAPACITY)
            full_sets++;
        if (set_bytes.size() > CAPACITY)
            dropping_sets++;
    endtask

    // Fill a set with one of several value profiles
    task automatic build_random_set(input int len);
        int         profile;
        logic [7:0] base;
        logic [7:0] v;
        profile = $urandom_range(0, 9);
        base = 8'($urandom_range(0, 255));
        set_bytes.delete();
        for (int k = 0; k < len; k++) begin
            case (profile)
                5, 6: v = (base > 8'd247) ? 8'(base - $urandom_range(0, 7))
                                          : 8'(base + $urandom_range(0, 7));
                7: v = ($urandom_range(0, 1) == 1) ? 8'(255 - $urandom_range(0, 1))
                                                   : 8'($urandom_range(0, 1));
                8: v = base;
                9: v = base ^ 8'($urandom_range(0, 3) << 6);
                default: v = 8'($urandom_range(0, 255));
            endcase
            set_bytes.push_back(v);
        end
    endtask

    // Receiver stall pattern, moving through four modes
    always @(negedge clk) begin
        rx_tick <= rx_tick + 10'd1;
        if (hold_off)
            m_tready <= 1'b0;
        else begin
            case (rx_tick[9:8])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= 1'($urandom_range(0, 1));
                2'd2: m_tready <= (rx_tick % 3 == 0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Hold the result side off once, long enough for the input to back up
    initial begin
        wait (checked >= 8);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Abort when neither side has moved an item for too long
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int len;
        int pick;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed sets: single extremes, even and odd medians, equal values
        steady = 1'b1;
        set_bytes = '{8'd0};
        send_set();
        set_bytes = '{8'd255};
        send_set();
        set_bytes = '{8'd255, 8'd0};
        send_set();
        set_bytes = '{8'd1, 8'd254, 8'd128};
        send_set();
        steady = 1'b0;
        set_bytes = '{8'd7, 8'd7, 8'd7, 8'd7};
        send_set();
        set_bytes = '{8'd200, 8'd100, 8'd50, 8'd25, 8'd12, 8'd6};
        send_set();
        set_bytes = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
        send_set();

        // Random sets; open with an exactly full store and one that drops its last
        while (samples_sent < SAMPLE_GOAL) begin
            if (sets_sent == 7)
                len = CAPACITY;
            else if (sets_sent == 8)
                len = CAPACITY + 6;
            else begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    len = $urandom_range(1, 8);
                else if (pick < 85)
                    len = $urandom_range(9, 32);
                else if (pick < 96)
                    len = $urandom_range(33, CAPACITY);
                else
                    len = $urandom_range(CAPACITY + 1, CAPACITY + 11);
            end
            steady = ($urandom_range(0, 4) == 0);
            build_random_set(len);
            send_set();
        end
        s_tvalid <= 1'b0;

        // Drain, then watch for stray results
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d sets, %0d samples; %0d reached a full store, %0d dropped samples",
                 sets_sent, samples_sent, full_sets, dropping_sets);
        $display("%0d results compared, with one %0d-cycle receiver hold",
                 checked, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bss_pkg.sv
rtl/core/bss_div.sv
rtl/core/byte_set_statistics_top.sv
sim/byte_set_statistics_checker.sv
sim/byte_set_statistics_top_test.sv
